// ===== src/tnr_pkg.sv =====
// Package with the Telnet command codes, option codes and phase type of the receive negotiator.
package tnr_pkg;

    localparam logic [7:0] C_IAC  = 8'd255;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_SB   = 8'd250;
    localparam logic [7:0] C_SE   = 8'd240;

    localparam logic [7:0] C_OPT_ECHO  = 8'd1;
    localparam logic [7:0] C_OPT_SGA   = 8'd3;
    localparam logic [7:0] C_OPT_TTYPE = 8'd24;

    localparam logic [7:0] C_TT_IS   = 8'd0;
    localparam logic [7:0] C_TT_SEND = 8'd1;

    localparam logic [31:0] C_TTYPE_RESET = 32'h414E_5349;

    // Positions within a reply burst: a 3-byte answer, then the 10-byte type report.
    localparam logic [3:0] C_POS_ANS_IAC  = 4'd0;
    localparam logic [3:0] C_POS_ANS_VERB = 4'd1;
    localparam logic [3:0] C_POS_ANS_OPT  = 4'd2;
    localparam logic [3:0] C_POS_TT_IAC   = 4'd3;
    localparam logic [3:0] C_POS_TT_SB    = 4'd4;
    localparam logic [3:0] C_POS_TT_OPT   = 4'd5;
    localparam logic [3:0] C_POS_TT_IS    = 4'd6;
    localparam logic [3:0] C_POS_TT_B3    = 4'd7;
    localparam logic [3:0] C_POS_TT_B2    = 4'd8;
    localparam logic [3:0] C_POS_TT_B1    = 4'd9;
    localparam logic [3:0] C_POS_TT_B0    = 4'd10;
    localparam logic [3:0] C_POS_TT_IAC2  = 4'd11;
    localparam logic [3:0] C_POS_TT_SE    = 4'd12;

    localparam logic C_DEST_DISPLAY = 1'b0;
    localparam logic C_DEST_NETWORK = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_IAC  = 3'b010,
        PH_VERB = 3'b100
    } t_phase;

endpackage

// ===== src/telnet_receive_negotiator.sv =====
// Receive-side Telnet negotiator: strips commands, answers options, emits display and reply bytes.
// The first result of an accepted item is registered and appears in the cycle after acceptance.
// Throughput: one input item per cycle while each yields at most one result and the output is
// not stalled; a longer burst holds the input, its bytes leaving one a cycle while i_m_tready is high.
// A new item is taken in the same cycle that the last byte of the previous burst is taken.
// Reset (synchronous, active low) clears the parser state and flags and loads the type "ANSI".
module telnet_receive_negotiator
    import tnr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] data_byte, [8] echo_off, [9] single_char, rest 0
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] destination
);

    logic [31:0] r_type_word;

    t_phase      r_phase, n_phase;
    logic        r_in_sub, n_in_sub;
    logic [7:0]  r_verb_pend, n_verb_pend;
    logic        r_sub_opt_vld, n_sub_opt_vld;
    logic [7:0]  r_sub_opt, n_sub_opt;
    logic        r_sub_cmd_vld, n_sub_cmd_vld;
    logic [7:0]  r_sub_cmd, n_sub_cmd;
    logic        r_echo, n_echo;
    logic        r_char, n_char;

    // Burst register: one accepted item's results, emitted by position.
    logic        r_busy;
    logic        r_dest, n_dest;
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_verb, n_verb;
    logic [3:0]  r_pos, n_pos;
    logic [3:0]  r_end, n_end;
    logic        r_out_echo;
    logic        r_out_char;
    logic        n_has;

    logic        in_fire;
    logic        out_fire;
    logic        out_last;
    logic [7:0]  b;
    logic [7:0]  out_byte;

    assign b        = i_s_tdata;
    assign out_last = (r_pos == r_end);
    assign out_fire = r_busy && i_m_tready;
    assign o_s_tready = !r_busy || (i_m_tready && out_last);
    assign in_fire  = i_s_tvalid && o_s_tready;

    always_comb begin
        n_phase       = r_phase;
        n_in_sub      = r_in_sub;
        n_verb_pend   = r_verb_pend;
        n_sub_opt_vld = r_sub_opt_vld;
        n_sub_opt     = r_sub_opt;
        n_sub_cmd_vld = r_sub_cmd_vld;
        n_sub_cmd     = r_sub_cmd;
        n_echo        = r_echo;
        n_char        = r_char;
        n_has         = 1'b0;
        n_dest        = C_DEST_NETWORK;
        n_byte        = b;
        n_verb        = C_WONT;
        n_pos         = C_POS_ANS_IAC;
        n_end         = C_POS_ANS_OPT;
        if (r_in_sub) begin
            if (r_phase == PH_IAC) begin
                n_phase = PH_IDLE;
                if (b == C_SE) begin
                    n_in_sub = 1'b0;
                    if (r_sub_opt_vld && r_sub_opt == C_OPT_TTYPE &&
                        r_sub_cmd_vld && r_sub_cmd == C_TT_SEND) begin
                        n_has = 1'b1;
                        n_pos = C_POS_TT_IAC;
                        n_end = C_POS_TT_SE;
                    end
                end
            end else if (b == C_IAC) begin
                n_phase = PH_IAC;
            end else if (!r_sub_opt_vld) begin
                n_sub_opt     = b;
                n_sub_opt_vld = 1'b1;
            end else if (!r_sub_cmd_vld) begin
                n_sub_cmd     = b;
                n_sub_cmd_vld = 1'b1;
            end
        end else if (r_phase == PH_IAC) begin
            n_phase = PH_IDLE;
            if (b == C_IAC) begin
                n_has  = 1'b1;
                n_dest = C_DEST_DISPLAY;
                n_end  = C_POS_ANS_IAC;
            end else if (b == C_SB) begin
                n_in_sub      = 1'b1;
                n_sub_opt_vld = 1'b0;
                n_sub_opt     = 8'd0;
                n_sub_cmd_vld = 1'b0;
                n_sub_cmd     = 8'd0;
            end else if (b == C_WILL || b == C_WONT || b == C_DO || b == C_DONT) begin
                n_verb_pend = b;
                n_phase     = PH_VERB;
            end
        end else if (r_phase == PH_VERB) begin
            n_phase = PH_IDLE;
            n_has   = 1'b1;
            if (b == C_OPT_ECHO) begin
                if (r_verb_pend == C_WILL) begin
                    n_echo = 1'b1;
                    n_verb = C_DO;
                end else if (r_verb_pend == C_WONT) begin
                    n_echo = 1'b0;
                    n_verb = C_DONT;
                end
            end else if (b == C_OPT_SGA) begin
                if (r_verb_pend == C_WILL) begin
                    n_char = 1'b1;
                    n_verb = C_DO;
                end else if (r_verb_pend == C_WONT) begin
                    n_char = 1'b0;
                    n_verb = C_DONT;
                end else if (r_verb_pend == C_DO) begin
                    n_char = 1'b1;
                    n_verb = C_WILL;
                end else begin
                    n_char = 1'b0;
                end
            end else if (b == C_OPT_TTYPE) begin
                if (r_verb_pend == C_DO) begin
                    n_verb = C_WILL;
                    n_end  = C_POS_TT_SE;
                end else if (r_verb_pend == C_WILL) begin
                    n_verb = C_DONT;
                end
            end else begin
                // Unknown options are refused; WONT and DONT need no answer.
                if (r_verb_pend == C_WILL) begin
                    n_verb = C_DONT;
                end else if (r_verb_pend != C_DO) begin
                    n_has = 1'b0;
                end
            end
        end else begin
            n_phase = PH_IDLE;
            if (b == C_IAC) begin
                n_phase = PH_IAC;
            end else if (b != 8'd0) begin
                n_has  = 1'b1;
                n_dest = C_DEST_DISPLAY;
                n_end  = C_POS_ANS_IAC;
            end
        end
    end

    always_comb begin
        case (r_pos)
            C_POS_ANS_IAC:  out_byte = C_IAC;
            C_POS_ANS_VERB: out_byte = r_verb;
            C_POS_ANS_OPT:  out_byte = r_byte;
            C_POS_TT_IAC:   out_byte = C_IAC;
            C_POS_TT_SB:    out_byte = C_SB;
            C_POS_TT_OPT:   out_byte = C_OPT_TTYPE;
            C_POS_TT_IS:    out_byte = C_TT_IS;
            C_POS_TT_B3:    out_byte = r_type_word[31:24];
            C_POS_TT_B2:    out_byte = r_type_word[23:16];
            C_POS_TT_B1:    out_byte = r_type_word[15:8];
            C_POS_TT_B0:    out_byte = r_type_word[7:0];
            C_POS_TT_IAC2:  out_byte = C_IAC;
            C_POS_TT_SE:    out_byte = C_SE;
            default:        out_byte = 8'd0;
        endcase
        if (r_dest == C_DEST_DISPLAY) begin
            out_byte = r_byte;
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {6'd0, r_out_char, r_out_echo, out_byte};
    assign o_m_tlast  = out_last;
    assign o_m_tuser  = r_dest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_word   <= C_TTYPE_RESET;
            r_phase       <= PH_IDLE;
            r_in_sub      <= 1'b0;
            r_verb_pend   <= 8'd0;
            r_sub_opt_vld <= 1'b0;
            r_sub_opt     <= 8'd0;
            r_sub_cmd_vld <= 1'b0;
            r_sub_cmd     <= 8'd0;
            r_echo        <= 1'b0;
            r_char        <= 1'b0;
            r_busy        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_type_word <= i_cfg_wr_data;
            end
            // A new burst takes over in the cycle the previous one hands out its last byte.
            if (in_fire && n_has) begin
                r_busy <= 1'b1;
            end else if (out_fire && out_last) begin
                r_busy <= 1'b0;
            end
            if (in_fire && n_has) begin
                r_pos <= n_pos;
            end else if (out_fire && !out_last) begin
                r_pos <= r_pos + 4'd1;
            end
            if (in_fire) begin
                r_phase       <= n_phase;
                r_in_sub      <= n_in_sub;
                r_verb_pend   <= n_verb_pend;
                r_sub_opt_vld <= n_sub_opt_vld;
                r_sub_opt     <= n_sub_opt;
                r_sub_cmd_vld <= n_sub_cmd_vld;
                r_sub_cmd     <= n_sub_cmd;
                r_echo        <= n_echo;
                r_char        <= n_char;
                if (n_has) begin
                    r_dest     <= n_dest;
                    r_byte     <= n_byte;
                    r_verb     <= n_verb;
                    r_end      <= n_end;
                    r_out_echo <= n_echo;
                    r_out_char <= n_char;
                end
            end
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= r_end))
        else $error("burst position beyond its end");

    a_display_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == C_DEST_DISPLAY) |-> o_m_tlast)
        else $error("display byte not marked last");

    a_accept_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_busy) |-> (i_m_tready && o_m_tlast))
        else $error("item accepted while a burst is still pending");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && !in_fire) |=> !o_m_tvalid)
        else $error("output valid after burst end without a new item");

    a_reply_starts_iac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_has && n_dest == C_DEST_NETWORK) |=> (o_m_tdata[7:0] == C_IAC))
        else $error("reply burst does not open with IAC");

endmodule
